// ===== rtl/ksc_pkg.sv =====
`timescale 1ns / 1ps

package ksc_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;

  // Widths of the CORDIC datapath: Q2.30 vectors with headroom, angle in turns.
  localparam int CW = 34;
  localparam int ZW = 33;

  // Pipeline stage numbers, counted from the input register as stage zero.
  localparam int NSTG         = CORDIC_STAGES + 6;
  localparam int ST_COST_TAP  = CORDIC_STAGES + 1;
  localparam int ST_CORD      = CORDIC_STAGES + 2;
  localparam int ST_R         = CORDIC_STAGES + 5;

  localparam int DATA_W = 120;

  localparam logic [31:0]          UNIT_STEP_COST = 32'd46325;
  localparam logic signed [CW-1:0] CORDIC_GAIN    = 34'sd652032874;
  localparam logic [31:0]          TWO_PI_Q29     = 32'd3373259426;
  localparam logic [31:0]          FRAC_HALF      = 32'(64'd1 << (31 - ANGLE_BITS));
  localparam logic [31:0]          FRAC_KEEP      = ~(32'((64'd1 << (32 - ANGLE_BITS)) - 64'd1));

  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [2:0] {
    CFG_STEP_LENGTH = 3'd0,
    CFG_STEER_TAN   = 3'd1,
    CFG_WHEELBASE   = 3'd2,
    CFG_PEN_TURN    = 3'd3,
    CFG_PEN_REV     = 3'd4,
    CFG_PEN_DIR     = 3'd5
  } cfg_reg_e;

  localparam logic [19:0] RST_STEP_LENGTH = 20'd46324;
  localparam logic [17:0] RST_STEER_TAN   = 18'd37837;
  localparam logic [23:0] RST_WHEELBASE   = 24'd131072;
  localparam logic [15:0] RST_PEN_TURN    = 16'd269;
  localparam logic [15:0] RST_PEN_REV     = 16'd512;
  localparam logic [15:0] RST_PEN_DIR     = 16'd512;

  // Primitives 0..2 drive forward, 3..5 backward.
  localparam logic [2:0] PRIM_FIRST_BACK = 3'd3;
  localparam logic [2:0] PRIM_LAST       = 3'd5;

  typedef enum logic [1:0] {
    STEER_NONE  = 2'd0,
    STEER_LEFT  = 2'd1,
    STEER_RIGHT = 2'd2
  } steer_e;

  // Geometry derived from the configuration, valid while ready is set.
  typedef struct packed {
    logic        ready;
    logic        straight;
    logic [31:0] frac;
    logic [40:0] radius;
  } geom_t;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [15:0] head;
    logic [31:0] pcost;
    logic [2:0]  pred;
    logic [2:0]  prim;
    logic [16:0] hsum;
  } side_t;

  typedef struct packed {
    logic [2:0]  prim;
    logic [31:0] cost;
    logic [15:0] heading;
    logic [31:0] y;
    logic [31:0] x;
  } out_t;

  function automatic steer_e steer_of(logic [2:0] p);
    steer_e s;
    unique case (p)
      3'd1, 3'd4: s = STEER_LEFT;
      3'd2, 3'd5: s = STEER_RIGHT;
      default:    s = STEER_NONE;
    endcase
    return s;
  endfunction

  function automatic logic is_back(logic [2:0] p);
    return p >= PRIM_FIRST_BACK;
  endfunction

endpackage

// ===== rtl/ksc_setup.sv =====
`timescale 1ns / 1ps

module ksc_setup import ksc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [19:0] step_i,
  input  logic [17:0] tan_i,
  input  logic [23:0] wb_i,
  output geom_t       geom_o
);

  localparam int DVD_W      = 83;
  localparam int BETA_SHIFT = 45;
  localparam int R_SHIFT    = 42;
  localparam logic [6:0] BETA_STEPS = 7'(DVD_W - 1);
  localparam logic [6:0] R_STEPS    = 7'(DVD_W - R_SHIFT - 1);

  typedef enum logic [4:0] {
    ST_MUL  = 5'b00001,
    ST_CMP  = 5'b00010,
    ST_DIVB = 5'b00100,
    ST_DIVR = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [37:0]      num_q;
  logic [55:0]      den_q;
  logic             straight_q;
  logic [DVD_W-1:0] dvd_q;
  logic [55:0]      rem_q;
  logic [40:0]      quo_q;
  logic [6:0]       cnt_q;
  logic [31:0]      frac_q;
  logic [40:0]      radius_q;

  logic [23:0] wb1;
  logic [47:0] num1000;
  logic [40:0] rdvd;
  logic [56:0] trial, dv, diff;
  logic        ge;
  logic [55:0] rem_nx;
  logic [40:0] quo_nx;

  assign wb1     = (wb_i == '0) ? 24'd1 : wb_i;
  assign num1000 = {num_q, 10'd0} - {6'd0, num_q, 4'd0} - {7'd0, num_q, 3'd0};
  assign rdvd    = {1'b0, wb1, 16'd0} + {24'd0, tan_i[17:1]};

  // One restoring division step per cycle, shared by both quotients.
  assign trial  = {rem_q, dvd_q[DVD_W-1]};
  assign dv     = (state_q == ST_DIVB) ? {1'b0, den_q} : {39'd0, tan_i};
  assign ge     = trial >= dv;
  assign diff   = trial - dv;
  assign rem_nx = ge ? diff[55:0] : trial[55:0];
  assign quo_nx = {quo_q[39:0], ge};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_MUL:  state_d = ST_CMP;
      ST_CMP:  state_d = ST_DIVB;
      ST_DIVB: if (cnt_q == '0) state_d = ST_DIVR;
      ST_DIVR: if (cnt_q == '0) state_d = ST_DONE;
      ST_DONE: state_d = ST_DONE;
      default: state_d = ST_MUL;
    endcase
    if (start_i) state_d = ST_MUL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_MUL;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_MUL: begin
        num_q <= {18'd0, step_i} * {20'd0, tan_i};
        den_q <= {32'd0, wb1} * {24'd0, TWO_PI_Q29};
      end
      ST_CMP: begin
        straight_q <= num1000 < {8'd0, wb1, 16'd0};
        dvd_q      <= {num_q, {BETA_SHIFT{1'b0}}};
        rem_q      <= '0;
        quo_q      <= '0;
        cnt_q      <= BETA_STEPS;
      end
      ST_DIVB: begin
        if (cnt_q == '0) begin
          frac_q <= (quo_nx[31:0] + FRAC_HALF) & FRAC_KEEP;
          dvd_q  <= {rdvd, {R_SHIFT{1'b0}}};
          rem_q  <= '0;
          quo_q  <= '0;
          cnt_q  <= R_STEPS;
        end else begin
          dvd_q <= dvd_q << 1;
          rem_q <= rem_nx;
          quo_q <= quo_nx;
          cnt_q <= cnt_q - 7'd1;
        end
      end
      ST_DIVR: begin
        dvd_q <= dvd_q << 1;
        rem_q <= rem_nx;
        quo_q <= quo_nx;
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == '0) radius_q <= quo_nx;
      end
      default: ;
    endcase
  end

  assign geom_o = '{ready: state_q == ST_DONE, straight: straight_q,
                    frac: frac_q, radius: radius_q};

endmodule

// ===== rtl/ksc_cordic.sv =====
`timescale 1ns / 1ps

module ksc_cordic import ksc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [31:0]          ang_i,
  output logic signed [CW-1:0] cos_o,
  output logic signed [CW-1:0] sin_o
);

  logic signed [CW-1:0] x_q [CORDIC_STAGES+1];
  logic signed [CW-1:0] y_q [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_q [CORDIC_STAGES+1];
  logic [CORDIC_STAGES:0] fl_q;

  logic        flip;
  logic [31:0] ang_f;

  // Angles in the left half-plane are turned by half a turn and negated at the end.
  assign flip  = ang_i[31] ^ ang_i[30];
  assign ang_f = {ang_i[31] ^ flip, ang_i[30:0]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]  <= CORDIC_GAIN;
      y_q[0]  <= '0;
      z_q[0]  <= $signed({ang_f[31], ang_f});
      fl_q[0] <= flip;
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        fl_q[k+1] <= fl_q[k];
        if (!z_q[k][ZW-1]) begin
          x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] - $signed({1'b0, ATAN_TURNS[k]});
        end else begin
          x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
          y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
          z_q[k+1] <= z_q[k] + $signed({1'b0, ATAN_TURNS[k]});
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cos_o <= fl_q[CORDIC_STAGES] ? -x_q[CORDIC_STAGES] : x_q[CORDIC_STAGES];
      sin_o <= fl_q[CORDIC_STAGES] ? -y_q[CORDIC_STAGES] : y_q[CORDIC_STAGES];
    end
  end

endmodule

// ===== rtl/ksc_cost.sv =====
`timescale 1ns / 1ps

module ksc_cost import ksc_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [2:0]  prim_i,
  input  logic [2:0]  pred_i,
  input  logic [15:0] pen_turn_i,
  input  logic [15:0] pen_rev_i,
  input  logic [15:0] pen_dir_i,
  input  logic [31:0] cost_i,
  output logic [31:0] cost_o
);

  // Q16.16 times Q8.8, rounded half up and saturated.
  function automatic logic [31:0] apply_factor(logic [31:0] v, logic [15:0] p);
    logic [47:0] prod;
    logic [47:0] rnd;
    prod = {16'd0, v} * {32'd0, p};
    rnd  = (prod + 48'd128) >> 8;
    return (rnd[47:32] != '0) ? 32'hFFFF_FFFF : rnd[31:0];
  endfunction

  logic        turn, back, dir;
  logic [31:0] inc1_q, inc2_q, inc3_q;
  logic [31:0] c1_q, c2_q, c3_q;
  logic        rev1_q, dir1_q, dir2_q;
  logic [32:0] sum;

  assign turn = pred_i != prim_i;
  assign back = is_back(prim_i);
  assign dir  = turn && (back ? (pred_i < PRIM_FIRST_BACK) : (pred_i >= PRIM_FIRST_BACK));
  assign sum  = {1'b0, c3_q} + {1'b0, inc3_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inc1_q <= turn ? apply_factor(UNIT_STEP_COST, pen_turn_i) : UNIT_STEP_COST;
      rev1_q <= back;
      dir1_q <= dir;
      c1_q   <= cost_i;
      inc2_q <= rev1_q ? apply_factor(inc1_q, pen_rev_i) : inc1_q;
      dir2_q <= dir1_q;
      c2_q   <= c1_q;
      inc3_q <= dir2_q ? apply_factor(inc2_q, pen_dir_i) : inc2_q;
      c3_q   <= c2_q;
      cost_o <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
  end

endmodule

// ===== rtl/kinematic_successor_with_cost.sv =====
`timescale 1ns / 1ps

// Kinematic successor for a hybrid A* search. Each input beat carries a parent
// pose, its cost and two motion primitives; each output beat carries the
// successor pose, the updated saturating cost and the applied primitive. The
// datapath takes one beat per clock while the output buffer has room and the
// setup divider is idle. A beat runs through two sixteen-stage CORDIC
// pipelines plus a split multiply and rounding tail; a two-entry output buffer
// lets the input keep flowing while a finished result waits. The arc radius
// and the heading increment depend only on the configuration, so they are
// computed once by a bit-serial divider: after reset and after every
// configuration write, s_axis_tready stays low while that divider runs.
// Configuration writes are expected only while the block holds no beats.
module kinematic_successor_with_cost import ksc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: parent_x, parent_y, parent_heading, parent_cost, parent_primitive,
  //        primitive_req, zero fill
  input  logic [DATA_W-1:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // tdata: succ_x, succ_y, succ_heading, succ_cost, succ_primitive, zero fill
  output logic [DATA_W-1:0] m_axis_tdata,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_addr_i,
  input  logic [23:0]       cfg_data_i
);

  // Configuration registers.
  logic [19:0] step_q;
  logic [17:0] tan_q;
  logic [23:0] wb_q;
  logic [15:0] pen_turn_q, pen_rev_q, pen_dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= RST_STEP_LENGTH;
      tan_q      <= RST_STEER_TAN;
      wb_q       <= RST_WHEELBASE;
      pen_turn_q <= RST_PEN_TURN;
      pen_rev_q  <= RST_PEN_REV;
      pen_dir_q  <= RST_PEN_DIR;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_STEP_LENGTH: step_q     <= cfg_data_i[19:0];
        CFG_STEER_TAN:   tan_q      <= cfg_data_i[17:0];
        CFG_WHEELBASE:   wb_q       <= cfg_data_i;
        CFG_PEN_TURN:    pen_turn_q <= cfg_data_i[15:0];
        CFG_PEN_REV:     pen_rev_q  <= cfg_data_i[15:0];
        CFG_PEN_DIR:     pen_dir_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Radius, heading increment and the straight-line decision.
  geom_t geom;

  ksc_setup u_setup (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cfg_we_i),
    .step_i (step_q),
    .tan_i  (tan_q),
    .wb_i   (wb_q),
    .geom_o (geom)
  );

  // The whole pipeline moves as one; it halts only when the output buffer is full.
  logic [1:0] fifo_cnt_q;
  logic       en;

  assign en            = fifo_cnt_q != 2'd2;
  assign s_axis_tready = en && geom.ready;

  logic [NSTG-1:0] vld_q;
  side_t           sd_q [NSTG];
  side_t           in_side;

  assign in_side = '{px: s_axis_tdata[31:0], py: s_axis_tdata[63:32],
                     head: s_axis_tdata[79:64], pcost: s_axis_tdata[111:80],
                     pred: s_axis_tdata[114:112], prim: s_axis_tdata[117:115],
                     hsum: '0};

  // Stage zero: the two angles fed to the CORDICs.
  logic [31:0] theta, beta, ang1;
  steer_e      st0;
  logic        neg0;
  side_t       sd1;

  assign theta = {sd_q[0].head, 16'd0};
  assign st0   = steer_of(sd_q[0].prim);
  assign neg0  = is_back(sd_q[0].prim) != (st0 == STEER_RIGHT);
  assign beta  = neg0 ? (32'd0 - geom.frac) : geom.frac;
  assign ang1  = theta + beta;

  // The successor heading, with one extra bit for rounding, travels with the beat from stage one on.
  always_comb begin
    sd1      = sd_q[0];
    sd1.hsum = ang1[31:15];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], s_axis_tvalid && s_axis_tready};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= in_side;
      sd_q[1] <= sd1;
      for (int i = 2; i < NSTG; i++) begin
        sd_q[i] <= sd_q[i-1];
      end
    end
  end

  logic signed [CW-1:0] c0, s0, c1, s1;

  ksc_cordic u_cordic_parent (
    .clk_i(clk_i),
    .en_i (en),
    .ang_i(theta),
    .cos_o(c0),
    .sin_o(s0)
  );

  ksc_cordic u_cordic_succ (
    .clk_i(clk_i),
    .en_i (en),
    .ang_i(ang1),
    .cos_o(c1),
    .sin_o(s1)
  );

  // Operand stage: a straight step scales the parent direction by the step
  // length, an arc scales the chord of the two unit vectors by the radius.
  logic signed [41:0] dmag, rmag, a_d, a_q;
  logic signed [34:0] c0x, s0x, c1x, s1x, bx_d, by_d, bx_q, by_q;
  steer_e             stc;
  logic               str_c;

  assign c0x   = 35'(c0);
  assign s0x   = 35'(s0);
  assign c1x   = 35'(c1);
  assign s1x   = 35'(s1);
  assign stc   = steer_of(sd_q[ST_CORD].prim);
  assign str_c = geom.straight || (stc == STEER_NONE);
  assign dmag  = $signed({22'd0, step_q});
  assign rmag  = $signed({1'b0, geom.radius});

  always_comb begin
    if (str_c) begin
      a_d  = is_back(sd_q[ST_CORD].prim) ? -dmag : dmag;
      bx_d = c0x;
      by_d = s0x;
    end else begin
      a_d  = (stc == STEER_RIGHT) ? -rmag : rmag;
      bx_d = s1x - s0x;
      by_d = c0x - c1x;
    end
  end

  // The wide operand is split into a low unsigned and a high signed part.
  logic signed [59:0] plx_q, ply_q;
  logic signed [52:0] phx_q, phy_q;
  logic [61:0]        sumx, sumy;
  logic [31:0]        mx_q, my_q;

  assign sumx = {phx_q[37:0], 24'd0} + {{2{plx_q[59]}}, plx_q} + (62'd1 << 29);
  assign sumy = {phy_q[37:0], 24'd0} + {{2{ply_q[59]}}, ply_q} + (62'd1 << 29);

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q   <= a_d;
      bx_q  <= bx_d;
      by_q  <= by_d;
      plx_q <= $signed({1'b0, a_q[23:0]}) * bx_q;
      phx_q <= $signed(a_q[41:24]) * bx_q;
      ply_q <= $signed({1'b0, a_q[23:0]}) * by_q;
      phy_q <= $signed(a_q[41:24]) * by_q;
      mx_q  <= sumx[61:30];
      my_q  <= sumy[61:30];
    end
  end

  logic [31:0] cost_q;

  ksc_cost u_cost (
    .clk_i     (clk_i),
    .en_i      (en),
    .prim_i    (sd_q[ST_COST_TAP].prim),
    .pred_i    (sd_q[ST_COST_TAP].pred),
    .pen_turn_i(pen_turn_q),
    .pen_rev_i (pen_rev_q),
    .pen_dir_i (pen_dir_q),
    .cost_i    (sd_q[ST_COST_TAP].pcost),
    .cost_o    (cost_q)
  );

  // Final assembly. An undefined request passes the parent through unchanged.
  side_t  sr;
  logic   inv, str_r;
  out_t   push_data;
  logic   push, pop;

  assign sr    = sd_q[ST_R];
  assign inv   = sr.prim > PRIM_LAST;
  assign str_r = geom.straight || (steer_of(sr.prim) == STEER_NONE);
  assign push  = en && vld_q[ST_R];
  assign pop   = m_axis_tvalid && m_axis_tready;

  always_comb begin
    push_data.prim = sr.prim;
    if (inv) begin
      push_data.x       = sr.px;
      push_data.y       = sr.py;
      push_data.heading = sr.head;
      push_data.cost    = sr.pcost;
    end else begin
      push_data.x       = sr.px + mx_q;
      push_data.y       = sr.py + my_q;
      push_data.heading = str_r ? sr.head : (sr.hsum[16:1] + {15'd0, sr.hsum[0]});
      push_data.cost    = cost_q;
    end
  end

  // Two-entry output buffer; entry zero is the head.
  out_t ent0_q, ent1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_cnt_q <= '0;
    end else begin
      fifo_cnt_q <= fifo_cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ent0_q <= (fifo_cnt_q == 2'd2) ? ent1_q : push_data;
    end else if (fifo_cnt_q == 2'd0) begin
      ent0_q <= push_data;
    end
    if (push && !pop && fifo_cnt_q == 2'd1) begin
      ent1_q <= push_data;
    end
  end

  assign m_axis_tvalid = fifo_cnt_q != 2'd0;
  assign m_axis_tdata  = {5'd0, ent0_q.prim, ent0_q.cost, ent0_q.heading, ent0_q.y, ent0_q.x};

  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("input accepted right after a configuration write");

  a_setup_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !geom.ready |-> !s_axis_tready)
    else $error("input accepted while geometry is being derived");

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q != 2'd3)
    else $error("output buffer overrun");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

endmodule
